// ----- sv/pba_pkg.sv -----
package pba_pkg;

   localparam int WORD_BITS = 64;
   localparam int NUM_WORDS = 1008;
   localparam int PORT_BASE = 1024;
   localparam int PORT_MAX = 65535;
   localparam int PORT_SPAN = NUM_WORDS * WORD_BITS;

   localparam int PORT_W = 16;
   localparam int STATUS_W = 2;
   localparam int WORD_IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int BIT_IDX_W = $clog2(WORD_BITS);
   localparam int OFF_W = PORT_W + 1;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OUT_OF_RANGE = 2'd2;

   typedef struct packed {
      logic              func;
      logic [PORT_W-1:0] release_port;
   } req_word_type;

   typedef struct packed {
      logic [PORT_W-1:0]   granted_port;
      logic [STATUS_W-1:0] status;
   } rsp_word_type;

   function automatic logic [WORD_BITS-1:0] word_init(input logic [WORD_IDX_W-1:0] idx);
      int base;
      logic [WORD_BITS-1:0] w;
      base = PORT_BASE + int'(idx) * WORD_BITS;
      for (int b = 0; b < WORD_BITS; b++) begin
         w[b] = ((base + b) <= PORT_MAX);
      end
      return w;
   endfunction

   function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [WORD_BITS-1:0] x);
      logic [BIT_IDX_W-1:0] idx;
      idx = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (x[b]) begin
            idx = BIT_IDX_W'(b);
         end
      end
      return idx;
   endfunction

   function automatic logic [WORD_IDX_W-1:0] next_word(input logic [WORD_IDX_W-1:0] idx);
      logic [WORD_IDX_W-1:0] nxt;
      if (idx == WORD_IDX_W'(NUM_WORDS - 1)) begin
         nxt = '0;
      end else begin
         nxt = idx + 1'b1;
      end
      return nxt;
   endfunction

endpackage

// ----- sv/pba_if.sv -----
interface pba_req_if;
   import pba_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface pba_rsp_if;
   import pba_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

// ----- sv/pba_ram.sv -----
module pba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/port_bitmap_allocator_unit.sv -----
// Next-fit port allocator over a free map held in one RAM (one bit per port, set = free).
// After reset a clearing pass writes every map word, while no word is accepted. An
// allocate checks the cursor word for a free bit; each further map word visited by
// the wraparound scan adds a scan step, since the map has a single read port and a scan
// reads one word per cycle. A release reads, modifies and writes back its word; one
// out of range goes straight to the result. One word is in work at a time; the result
// sits in an output register, so the block returns to idle once the result is loaded.
module port_bitmap_allocator_unit (
   input logic      clock,
   input logic      reset,
   pba_req_if.sink  req_chan,
   pba_rsp_if.source rsp_chan
);
   import pba_pkg::*;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_LOOK  = 6'b000100,
      ST_SCAN  = 6'b001000,
      ST_REL   = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [WORD_IDX_W-1:0] clr_ff, clr_in;
   logic [WORD_IDX_W-1:0] cur_word_ff, cur_word_in;
   logic [WORD_BITS-1:0]  cur_mask_ff, cur_mask_in;
   logic [WORD_IDX_W-1:0] scan_ff, scan_in;
   logic [BIT_IDX_W-1:0]  rbit_ff, rbit_in;
   logic                  wr_en_ff, wr_en_in;
   logic [WORD_IDX_W-1:0] wr_addr_ff, wr_addr_in;
   logic [WORD_BITS-1:0]  wr_data_ff, wr_data_in;
   logic [PORT_W-1:0]     res_port_ff, res_port_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   logic                  ram_we;
   logic [WORD_IDX_W-1:0] ram_waddr;
   logic [WORD_BITS-1:0]  ram_wdata;
   logic [WORD_IDX_W-1:0] ram_raddr;
   logic [WORD_BITS-1:0]  ram_rdata;

   logic                  req_fire;
   logic                  rsp_free;
   logic [OFF_W-1:0]      rel_off;
   logic                  rel_in_range;
   logic [WORD_IDX_W-1:0] rel_word;
   logic [BIT_IDX_W-1:0]  rel_bit;
   logic [WORD_BITS-1:0]  look_avail;
   logic [WORD_IDX_W-1:0] g_word;
   logic [WORD_BITS-1:0]  g_avail;
   logic [BIT_IDX_W-1:0]  g_bit;
   logic [WORD_IDX_W-1:0] nxt_word;

   pba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NUM_WORDS)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.word = rsp_word_ff;

   assign rel_off = OFF_W'(req_chan.word.release_port) - OFF_W'(PORT_BASE);
   assign rel_in_range = (32'(req_chan.word.release_port) >= PORT_BASE)
                         && (32'(rel_off) < PORT_SPAN);
   assign rel_word = WORD_IDX_W'(rel_off / WORD_BITS);
   assign rel_bit = BIT_IDX_W'(rel_off % WORD_BITS);

   assign look_avail = ram_rdata & cur_mask_ff;
   assign g_word = (state_ff == ST_LOOK) ? cur_word_ff : scan_ff;
   assign g_avail = (state_ff == ST_LOOK) ? look_avail : ram_rdata;
   assign g_bit = lowest_set(g_avail);
   assign nxt_word = next_word(g_word);

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      cur_word_in = cur_word_ff;
      cur_mask_in = cur_mask_ff;
      scan_in = scan_ff;
      rbit_in = rbit_ff;
      wr_en_in = wr_en_ff;
      wr_addr_in = wr_addr_ff;
      wr_data_in = wr_data_ff;
      res_port_in = res_port_ff;
      res_status_in = res_status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_word_in = rsp_word_ff;
      ram_we = 1'b0;
      ram_waddr = wr_addr_ff;
      ram_wdata = wr_data_ff;
      ram_raddr = cur_word_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = word_init(clr_ff);
            clr_in = clr_ff + 1'b1;
            if (clr_ff == WORD_IDX_W'(NUM_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.word.func == FUNC_ALLOC) begin
                  state_in = ST_LOOK;
               end else if (rel_in_range) begin
                  ram_raddr = rel_word;
                  wr_addr_in = rel_word;
                  rbit_in = rel_bit;
                  state_in = ST_REL;
               end else begin
                  wr_en_in = 1'b0;
                  res_port_in = '0;
                  res_status_in = STATUS_OUT_OF_RANGE;
                  state_in = ST_RESP;
               end
            end
         end
         ST_LOOK, ST_SCAN: begin
            if (g_avail != '0) begin
               cur_word_in = g_word;
               cur_mask_in = ({WORD_BITS{1'b1}} << g_bit) << 1;
               wr_en_in = 1'b1;
               wr_addr_in = g_word;
               wr_data_in = ram_rdata & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << g_bit);
               res_port_in = PORT_W'(PORT_BASE + int'(g_word) * WORD_BITS + int'(g_bit));
               res_status_in = STATUS_OK;
               state_in = ST_RESP;
            end else if (nxt_word == cur_word_ff) begin
               wr_en_in = 1'b0;
               res_port_in = '0;
               res_status_in = STATUS_NO_FREE;
               state_in = ST_RESP;
            end else begin
               ram_raddr = nxt_word;
               scan_in = nxt_word;
               state_in = ST_SCAN;
            end
         end
         ST_REL: begin
            wr_en_in = 1'b1;
            wr_data_in = ram_rdata | ({{(WORD_BITS-1){1'b0}}, 1'b1} << rbit_ff);
            res_port_in = '0;
            res_status_in = STATUS_OK;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) begin
               ram_we = wr_en_ff;
               rsp_valid_in = 1'b1;
               rsp_word_in.granted_port = res_port_ff;
               rsp_word_in.status = res_status_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         cur_word_ff <= '0;
         cur_mask_ff <= '1;
         wr_en_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         cur_word_ff <= cur_word_in;
         cur_mask_ff <= cur_mask_in;
         wr_en_ff <= wr_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      rbit_ff <= rbit_in;
      wr_addr_ff <= wr_addr_in;
      wr_data_ff <= wr_data_in;
      res_port_ff <= res_port_in;
      res_status_ff <= res_status_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule

// ----- sv/pba_checker.sv -----
module pba_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [pba_pkg::PORT_W-1:0]     rsp_granted_port,
   input logic [pba_pkg::STATUS_W-1:0]   rsp_status
);
   import pba_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_granted_port) && $stable(rsp_status))
      else $error("response word changed while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another word is in work");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STATUS_OK || rsp_status == STATUS_NO_FREE
                    || rsp_status == STATUS_OUT_OF_RANGE)
      else $error("undefined status code");

   a_port_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_granted_port == '0)
      else $error("port reported with a failing status");

endmodule

bind port_bitmap_allocator_unit pba_checker u_pba_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_granted_port (rsp_chan.word.granted_port),
   .rsp_status       (rsp_chan.word.status)
);

// ----- verif/pba_checker.sv -----
module pba_scoreboard (
   input logic clock,
   input logic reset,
   pba_req_if  req_mon,
   pba_rsp_if  rsp_mon,
   output int  mismatches,
   output int  outstanding
);
   import pba_pkg::*;

   logic [WORD_BITS-1:0] free_bits [NUM_WORDS];
   int                   scan_word;
   logic [WORD_BITS-1:0] above_mask;
   rsp_word_type         pending_answers [$];
   int                   errors = 0;
   int                   backlog = 0;

   assign mismatches = errors;
   assign outstanding = backlog;

   task automatic report(input string what, input int got, input int want);
      errors++;
      $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
   endtask

   function automatic void clear_map();
      for (int w = 0; w < NUM_WORDS; w++) begin
         for (int b = 0; b < WORD_BITS; b++) begin
            free_bits[w][b] = ((PORT_BASE + w * WORD_BITS + b) <= PORT_MAX);
         end
      end
      scan_word = 0;
      above_mask = '1;
   endfunction

   function automatic rsp_word_type serve_request(input req_word_type rq);
      rsp_word_type         answer;
      int                   idx;
      int                   first;
      int                   b;
      int                   port;
      int                   off;
      logic [WORD_BITS-1:0] avail;
      answer.granted_port = '0;
      answer.status = STATUS_OK;
      if (rq.func == FUNC_ALLOC) begin
         idx = (scan_word >= NUM_WORDS) ? 0 : scan_word;
         first = idx;
         if ((free_bits[idx] & above_mask) == '0) begin
            do begin
               idx++;
               if (idx >= NUM_WORDS) begin
                  idx = 0;
               end
               if (idx == first) begin
                  answer.status = STATUS_NO_FREE;
                  return answer;
               end
            end while (free_bits[idx] == '0);
            above_mask = '1;
         end
         scan_word = idx;
         avail = free_bits[idx] & above_mask;
         b = 0;
         while (b < WORD_BITS && !avail[b]) begin
            b++;
         end
         if (b >= WORD_BITS - 1) begin
            above_mask = '0;
         end else begin
            above_mask = {WORD_BITS{1'b1}} << (b + 1);
         end
         free_bits[idx][b] = 1'b0;
         answer.granted_port = PORT_W'(PORT_BASE + idx * WORD_BITS + b);
      end else begin
         port = int'(rq.release_port);
         off = port - PORT_BASE;
         if (port < PORT_BASE || off >= PORT_SPAN) begin
            answer.status = STATUS_OUT_OF_RANGE;
         end else begin
            free_bits[off / WORD_BITS][off % WORD_BITS] = 1'b1;
         end
      end
      return answer;
   endfunction

   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      if (reset) begin
         clear_map();
         pending_answers.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            pending_answers.push_back(serve_request(req_mon.word));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.word;
            if (pending_answers.size() == 0) begin
               report("result with nothing pending, status", int'(got.status), -1);
            end else begin
               want = pending_answers.pop_front();
               if (got.granted_port !== want.granted_port) begin
                  report("granted_port", int'(got.granted_port), int'(want.granted_port));
               end
               if (got.status !== want.status) begin
                  report("status", int'(got.status), int'(want.status));
               end
            end
         end
      end
      backlog = pending_answers.size();
   end

endmodule

// ----- verif/tb.sv -----
module tb;
   import pba_pkg::*;

   logic clock;
   logic reset;
   int   mismatches;
   int   outstanding;
   int   burst_left;
   int   alloc_est;
   bit   light;
   int   stall_mode;
   int   stall_left;
   logic [31:0] stall_pat;

   pba_req_if req_if();
   pba_rsp_if rsp_if();

   port_bitmap_allocator_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   pba_scoreboard i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(8, 200);
         stall_pat = $urandom;
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: begin
            rsp_if.ready <= 1'b1;
         end
         1: begin
            rsp_if.ready <= 1'($urandom_range(0, 1));
         end
         2: begin
            rsp_if.ready <= stall_pat[stall_left % 32];
         end
         default: begin
            rsp_if.ready <= ($urandom_range(0, 7) != 0);
         end
      endcase
   end

   task automatic push_word(input logic f, input logic [PORT_W-1:0] p);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if (light) begin
            gap = ($urandom_range(0, 15) == 0) ? 1 : 0;
         end else begin
            gap = $urandom_range(0, 6);
         end
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_if.valid <= 1'b1;
      req_if.word <= '{func: f, release_port: p};
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      burst_left = 0;
   endtask

   initial begin
      int pick;
      int near;
      int waited;
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.word = '0;
      rsp_if.ready = 1'b0;
      burst_left = 0;
      alloc_est = 0;
      light = 1'b0;
      stall_left = 0;
      stall_mode = 0;
      stall_pat = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      push_word(FUNC_ALLOC, '1);
      push_word(FUNC_ALLOC, '0);
      push_word(FUNC_RELEASE, PORT_W'(PORT_BASE));
      push_word(FUNC_ALLOC, 16'h5555);
      push_word(FUNC_RELEASE, PORT_W'(PORT_BASE - 1));
      push_word(FUNC_RELEASE, '0);
      push_word(FUNC_RELEASE, PORT_W'(PORT_MAX));
      push_word(FUNC_RELEASE, PORT_W'(PORT_MAX));
      push_word(FUNC_RELEASE, PORT_W'(PORT_BASE + 1));
      push_word(FUNC_RELEASE, 16'hAAAA);
      push_word(FUNC_ALLOC, 16'hAAAA);
      push_word(FUNC_RELEASE, PORT_W'(PORT_BASE + WORD_BITS - 1));
      push_word(FUNC_ALLOC, '0);
      alloc_est = 4;
      drain();

      for (int n = 0; n < 1300; n++) begin
         if (n == 800) begin
            drain();
         end
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            push_word(FUNC_ALLOC, PORT_W'($urandom));
            alloc_est++;
         end else if (pick < 88) begin
            near = PORT_BASE + (alloc_est % PORT_SPAN) - int'($urandom_range(1, 150));
            if (near < PORT_BASE) begin
               near = PORT_BASE + int'($urandom_range(0, 255));
            end
            push_word(FUNC_RELEASE, PORT_W'(near));
         end else if (pick < 94) begin
            push_word(FUNC_RELEASE, PORT_W'($urandom));
         end else begin
            push_word(FUNC_RELEASE, PORT_W'($urandom_range(0, PORT_BASE - 1)));
         end
      end

      light = 1'b1;
      for (int n = 0; n < 200; n++) begin
         push_word(FUNC_ALLOC, PORT_W'($urandom));
      end
      light = 1'b0;

      push_word(FUNC_RELEASE, PORT_W'(PORT_MAX));
      push_word(FUNC_ALLOC, '0);
      push_word(FUNC_ALLOC, '0);
      push_word(FUNC_RELEASE, PORT_W'(PORT_BASE));
      push_word(FUNC_ALLOC, '0);
      for (int n = 0; n < 150; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            push_word(FUNC_ALLOC, PORT_W'($urandom));
         end else if (pick < 85) begin
            push_word(FUNC_RELEASE, PORT_W'($urandom_range(PORT_BASE, PORT_MAX)));
         end else begin
            push_word(FUNC_RELEASE, PORT_W'($urandom));
         end
      end

      req_if.valid <= 1'b0;
      waited = 0;
      while (outstanding != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      repeat (20) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #400000000;
      $display("status: fail");
      $finish;
   end

endmodule
